// File: hdl/point_in_triangle_test_unit_defines.svh
// Assertion macros used by the checker file of the point-in-triangle unit
`ifndef POINT_IN_TRIANGLE_TEST_UNIT_DEFINES_SVH
`define POINT_IN_TRIANGLE_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off while rst_n is low
`define PTT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("point_in_triangle_test_unit: check failed");

// Next-cycle implication
`define PTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("point_in_triangle_test_unit: check failed");

`endif

// File: hdl/ptt_pkg.sv
// Types and constants of the point-in-triangle unit
package ptt_pkg;

  localparam int CoordBits = 16;
  localparam int DiffBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * DiffBits;

  // orientation slots
  localparam int OrAbc   = 0;
  localparam int OrApc   = 1;
  localparam int OrAbp   = 2;
  localparam int OrBcp   = 3;
  localparam int NumOr   = 4;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;
  typedef logic signed [ProdBits-1:0]  prod_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    coord_t vert_a_x;
    coord_t vert_a_y;
    coord_t vert_a_z;
    coord_t vert_b_x;
    coord_t vert_b_y;
    coord_t vert_b_z;
    coord_t vert_c_x;
    coord_t vert_c_y;
    coord_t vert_c_z;
  } ptt_in_t;

  typedef struct packed {
    logic inside_res;
    logic in_box;
  } ptt_out_t;

  // stage 1: coordinate differences
  typedef struct packed {
    logic  valid;
    logic  box;
    diff_t acx;
    diff_t acy;
    diff_t bcx;
    diff_t bcy;
    diff_t pcx;
    diff_t pcy;
    diff_t apx;
    diff_t apy;
    diff_t bpx;
    diff_t bpy;
    diff_t cpx;
    diff_t cpy;
  } ptt_diff_t;

  // stage 2: the two products of each orientation
  typedef struct packed {
    logic              valid;
    logic              box;
    prod_t [NumOr-1:0] lhs;
    prod_t [NumOr-1:0] rhs;
  } ptt_prod_t;

  // stage 3: orientation signs
  typedef struct packed {
    logic             valid;
    logic             box;
    logic [NumOr-1:0] pos;
    logic [NumOr-1:0] neg;
  } ptt_sign_t;

endpackage

// File: hdl/ptt_diff.sv
// Stage 1: bounding-box test and coordinate differences
module ptt_diff (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  input  ptt_pkg::ptt_in_t req_i,
  output ptt_pkg::ptt_diff_t diff_o
);
  import ptt_pkg::*;

  ptt_diff_t diff_r, diff_nxt;

  function automatic logic in_bounds(coord_t p, coord_t a, coord_t b, coord_t c);
    in_bounds = (p >= a || p >= b || p >= c) && (p <= a || p <= b || p <= c);
  endfunction

  function automatic diff_t sub(coord_t u, coord_t v);
    sub = DiffBits'(u) - DiffBits'(v);
  endfunction

  always_comb begin
    diff_nxt.valid = valid_i;
    // z takes part in the box only
    diff_nxt.box = in_bounds(req_i.point_x, req_i.vert_a_x, req_i.vert_b_x, req_i.vert_c_x) &&
                   in_bounds(req_i.point_y, req_i.vert_a_y, req_i.vert_b_y, req_i.vert_c_y) &&
                   in_bounds(req_i.point_z, req_i.vert_a_z, req_i.vert_b_z, req_i.vert_c_z);
    diff_nxt.acx = sub(req_i.vert_a_x, req_i.vert_c_x);
    diff_nxt.acy = sub(req_i.vert_a_y, req_i.vert_c_y);
    diff_nxt.bcx = sub(req_i.vert_b_x, req_i.vert_c_x);
    diff_nxt.bcy = sub(req_i.vert_b_y, req_i.vert_c_y);
    diff_nxt.pcx = sub(req_i.point_x, req_i.vert_c_x);
    diff_nxt.pcy = sub(req_i.point_y, req_i.vert_c_y);
    diff_nxt.apx = sub(req_i.vert_a_x, req_i.point_x);
    diff_nxt.apy = sub(req_i.vert_a_y, req_i.point_y);
    diff_nxt.bpx = sub(req_i.vert_b_x, req_i.point_x);
    diff_nxt.bpy = sub(req_i.vert_b_y, req_i.point_y);
    diff_nxt.cpx = sub(req_i.vert_c_x, req_i.point_x);
    diff_nxt.cpy = sub(req_i.vert_c_y, req_i.point_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_r <= '0;
    end else begin
      diff_r <= diff_nxt;
    end
  end

  assign diff_o = diff_r;

endmodule

// File: hdl/ptt_mul.sv
// Stage 2: cross products of the four orientations
module ptt_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  ptt_pkg::ptt_diff_t diff_i,
  output ptt_pkg::ptt_prod_t prod_o
);
  import ptt_pkg::*;

  ptt_prod_t prod_r, prod_nxt;

  always_comb begin
    prod_nxt.valid = diff_i.valid;
    prod_nxt.box   = diff_i.box;
    // o(u,v,w) = (ux-wx)*(vy-wy) - (uy-wy)*(vx-wx)
    prod_nxt.lhs[OrAbc] = diff_i.acx * diff_i.bcy;
    prod_nxt.rhs[OrAbc] = diff_i.acy * diff_i.bcx;
    prod_nxt.lhs[OrApc] = diff_i.acx * diff_i.pcy;
    prod_nxt.rhs[OrApc] = diff_i.acy * diff_i.pcx;
    prod_nxt.lhs[OrAbp] = diff_i.apx * diff_i.bpy;
    prod_nxt.rhs[OrAbp] = diff_i.apy * diff_i.bpx;
    prod_nxt.lhs[OrBcp] = diff_i.bpx * diff_i.cpy;
    prod_nxt.rhs[OrBcp] = diff_i.bpy * diff_i.cpx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= '0;
    end else begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_o = prod_r;

endmodule

// File: hdl/ptt_sign.sv
// Stage 3: sign of each orientation from its two products
module ptt_sign (
  input  logic               clk,
  input  logic               rst_n,
  input  ptt_pkg::ptt_prod_t prod_i,
  output ptt_pkg::ptt_sign_t sign_o
);
  import ptt_pkg::*;

  ptt_sign_t sign_r, sign_nxt;

  always_comb begin
    sign_nxt.valid = prod_i.valid;
    sign_nxt.box   = prod_i.box;
    for (int i = 0; i < NumOr; i++) begin
      sign_nxt.pos[i] = prod_i.lhs[i] > prod_i.rhs[i];
      sign_nxt.neg[i] = prod_i.lhs[i] < prod_i.rhs[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sign_r <= '0;
    end else begin
      sign_r <= sign_nxt;
    end
  end

  assign sign_o = sign_r;

endmodule

// File: hdl/point_in_triangle_test_unit.sv
// Point-in-triangle test: top level of a four-stage pipeline
// A request taken from in_req passes the difference, product, sign and output registers on its way to out_res.
// Throughput: one request per cycle while busy is low; the pipeline never stalls and results cannot be held off.
// Stages: box test and differences, multipliers, product compare, sign combine.
// Synchronous active-low reset clears every stage valid bit and holds busy high.
module point_in_triangle_test_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ptt_pkg::ptt_in_t  in_req,
  output logic              out_valid,
  output ptt_pkg::ptt_out_t out_res
);
  import ptt_pkg::*;

  ptt_diff_t diff;
  ptt_prod_t prod;
  ptt_sign_t sign;

  logic     busy_r;
  logic     out_valid_r, out_valid_nxt;
  ptt_out_t out_res_r, out_res_nxt;
  logic     all_nz;
  logic     odd_neg;

  ptt_diff u_ptt_diff (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start && !busy_r),
    .req_i   (in_req),
    .diff_o  (diff)
  );

  ptt_mul u_ptt_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .diff_i (diff),
    .prod_o (prod)
  );

  ptt_sign u_ptt_sign (
    .clk    (clk),
    .rst_n  (rst_n),
    .prod_i (prod),
    .sign_o (sign)
  );

  // Only the first orientation set is formed: each of the second set is the
  // same triple with two vertices swapped, so its product has the opposite sign.
  always_comb begin
    all_nz  = (sign.pos[OrApc] | sign.neg[OrApc]) &
              (sign.pos[OrAbp] | sign.neg[OrAbp]) &
              (sign.pos[OrBcp] | sign.neg[OrBcp]);
    odd_neg = sign.neg[OrApc] ^ sign.neg[OrAbp] ^ sign.neg[OrBcp];
    out_valid_nxt          = sign.valid;
    out_res_nxt.in_box     = sign.box;
    out_res_nxt.inside_res = sign.box && all_nz &&
                             (sign.pos[OrAbc] ? !odd_neg : odd_neg);
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    if (!rst_n) begin
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// File: hdl/ptt_checker.sv
// Port-level checks of the point-in-triangle unit, bound to the top level
`include "point_in_triangle_test_unit_defines.svh"

module ptt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input ptt_pkg::ptt_in_t  in_req,
  input logic              out_valid,
  input ptt_pkg::ptt_out_t out_res
);

  logic       acc;
  logic       run4;
  logic       on_vertex;
  logic [3:0] rst_hist_r;

  // reset seen high at every edge held in rst_hist_r
  always_ff @(posedge clk) begin
    rst_hist_r <= {rst_hist_r[2:0], rst_n};
  end

  assign acc       = start && !busy;
  assign run4      = &rst_hist_r;
  assign on_vertex = acc && in_req.point_x == in_req.vert_a_x &&
                     in_req.point_y == in_req.vert_a_y && in_req.point_z == in_req.vert_a_z;

  // a point inside always lies in the box
  `PTT_ASSERT_IMPLY(a_inside_in_box, out_valid, !out_res.inside_res || out_res.in_box)
  // every request gives one result on out_valid
  `PTT_ASSERT_IMPLY(a_latency, run4, out_valid == $past(acc, 4))
  // a point on a vertex is in the box but never strictly inside
  `PTT_ASSERT_IMPLY(a_vertex, run4 && $past(on_vertex, 4),
                    out_valid && out_res.in_box && !out_res.inside_res)
  // ready again once out of reset
  `PTT_ASSERT_NEXT(a_ready, rst_n, !busy)

endmodule

bind point_in_triangle_test_unit ptt_checker u_ptt_checker (.*);
